// File: design/double_ended_queue_macros.svh
// Assertion macros for the double-ended queue.
// Included by the top level; needs a clock and an active-low reset name.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication
`define DEQ_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DEQ_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/deq_pkg.sv
// Shared types, constants and index helper for the double-ended queue.
// No dependencies; used by deq_ctrl, deq_datapath and the top level.
package deq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam cnt_t CAP_CNT      = CNT_W'(CAPACITY);
    localparam idx_t CAP_LAST_IDX = IDX_W'(CAPACITY - 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_PUSHED = 3'd0,
        ST_POPPED = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_FULL   = 3'd3,
        ST_LISTED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_PUSH_BACK  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_BACK   = 3'd4,
        ACT_LIST_START = 3'd5,
        ACT_LIST_NEXT  = 3'd6
    } act_t;

    typedef struct packed {
        act_t    act;
        logic    load_out;
        status_t out_status;
        logic    out_use_ram;
        logic    out_last;
    } deq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;
        logic out_free;
        cnt_t count;
    } deq_stat_t;

    // (base + offs) mod CAPACITY, both operands below CAPACITY
    function automatic idx_t wrap_add(idx_t base, idx_t offs);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= (IDX_W + 1)'(CAPACITY)) begin
            sum = sum - (IDX_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: design/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/deq_ctrl.sv
// Controller of the double-ended queue: decodes operations, sequences reads.
// Depends on deq_pkg.
module deq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [deq_pkg::OP_W-1:0] op,
    input  deq_pkg::deq_stat_t   stat,
    output deq_pkg::deq_cmd_t    cmd
);
    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   list_mode_reg, list_mode_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        list_mode_next  = list_mode_reg;
        cmd.act         = ACT_NONE;
        cmd.load_out    = 1'b0;
        cmd.out_status  = ST_PUSHED;
        cmd.out_use_ram = 1'b0;
        cmd.out_last    = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (op_t'(op))
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            cmd.load_out = 1'b1;
                            if (stat.full) begin
                                cmd.out_status = ST_FULL;
                            end else begin
                                cmd.act = (op_t'(op) == OP_PUSH_FRONT) ?
                                          ACT_PUSH_FRONT : ACT_PUSH_BACK;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_LIST: begin
                            if (stat.empty) begin
                                cmd.load_out   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                state_next     = S_READ;
                                list_mode_next = (op_t'(op) == OP_LIST);
                                unique case (op_t'(op))
                                    OP_POP_FRONT: cmd.act = ACT_POP_FRONT;
                                    OP_POP_BACK:  cmd.act = ACT_POP_BACK;
                                    default:      cmd.act = ACT_LIST_START;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (stat.out_free) begin
                    cmd.load_out    = 1'b1;
                    cmd.out_use_ram = 1'b1;
                    cmd.out_status  = list_mode_reg ? ST_LISTED : ST_POPPED;
                    cmd.out_last    = !list_mode_reg || stat.list_last;
                    if (list_mode_reg && !stat.list_last) begin
                        cmd.act = ACT_LIST_NEXT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            list_mode_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            list_mode_reg <= list_mode_next;
        end
    end

endmodule

// File: design/deq_datapath.sv
// Datapath of the double-ended queue: ring pointers, entry RAM, output register.
// Depends on deq_pkg and deq_ram.
module deq_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  deq_pkg::deq_cmd_t    cmd,
    input  deq_pkg::word_t       value_in,
    input  logic                 m_tready,
    output deq_pkg::deq_stat_t   stat,
    output logic                 out_valid,
    output deq_pkg::word_t       out_value,
    output deq_pkg::status_t     out_status,
    output logic                 out_last
);
    import deq_pkg::*;

    idx_t    front_reg, front_next;
    cnt_t    count_reg, count_next;
    idx_t    list_idx_reg, list_idx_next, list_idx_inc;
    logic    out_valid_reg, out_valid_next;
    status_t out_status_reg, out_status_next;
    word_t   out_value_reg, out_value_next;
    logic    out_last_reg, out_last_next;

    logic    wr_en, rd_en;
    idx_t    wr_addr, rd_addr;
    word_t   rd_data;

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign list_idx_inc = list_idx_reg + idx_t'(1);

    always_comb begin
        front_next    = front_reg;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        wr_en         = 1'b0;
        wr_addr       = front_reg;
        rd_en         = 1'b0;
        rd_addr       = front_reg;
        unique case (cmd.act)
            ACT_PUSH_FRONT: begin
                front_next = (front_reg == '0) ? CAP_LAST_IDX : front_reg - idx_t'(1);
                wr_en      = 1'b1;
                wr_addr    = front_next;
                count_next = count_reg + cnt_t'(1);
            end
            ACT_PUSH_BACK: begin
                wr_en      = 1'b1;
                wr_addr    = wrap_add(front_reg, IDX_W'(count_reg));
                count_next = count_reg + cnt_t'(1);
            end
            ACT_POP_FRONT: begin
                rd_en      = 1'b1;
                front_next = wrap_add(front_reg, idx_t'(1));
                count_next = count_reg - cnt_t'(1);
            end
            ACT_POP_BACK: begin
                rd_en      = 1'b1;
                rd_addr    = wrap_add(front_reg, IDX_W'(count_reg - cnt_t'(1)));
                count_next = count_reg - cnt_t'(1);
            end
            ACT_LIST_START: begin
                rd_en         = 1'b1;
                list_idx_next = '0;
            end
            ACT_LIST_NEXT: begin
                rd_en         = 1'b1;
                rd_addr       = wrap_add(front_reg, list_idx_inc);
                list_idx_next = list_idx_inc;
            end
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        if (cmd.load_out) begin
            out_valid_next  = 1'b1;
            out_status_next = cmd.out_status;
            out_value_next  = cmd.out_use_ram ? rd_data : '0;
            out_last_next   = cmd.out_last;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            list_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            list_idx_reg  <= list_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CAP_CNT);
    assign stat.list_last = ((cnt_t'(list_idx_reg) + cnt_t'(1)) == count_reg);
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.count     = count_reg;

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

// File: design/double_ended_queue.sv
// Top level of the bounded double-ended queue of 32-bit words.
// Depends on deq_pkg, deq_ctrl, deq_datapath and double_ended_queue_macros.svh.
//
// Usage:
//   Input stream: s_tuser carries the operation (push front, push back, pop front,
//   pop back, list), s_tdata the word to push. Result stream: m_tuser carries the
//   status, m_tdata the popped or listed word, m_tlast flags the final result of
//   an operation. Every operation but an unknown code gives at least one result.
//   Push, full, and empty results are valid the cycle after the input transfer;
//   a pop result goes through the registered RAM read, then the output register.
//   A push can be taken every cycle while the result stream is not stalled. Due
//   to the single RAM read port, a pop holds off input until its result is loaded,
//   and a listing gives one entry per cycle while results are taken and holds off input.
//   Reset empties the queue and clears the output valid flag; stored words are
//   not cleared and need no clearing pass.
//   While m_tready is low the result register holds and s_tready drops once a
//   result is pending; no transfer is lost.
`include "double_ended_queue_macros.svh"

module double_ended_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_in (signed)
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_out (signed)
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);
    import deq_pkg::*;

    deq_cmd_t  dp_cmd;
    deq_stat_t dp_stat;
    status_t   out_status;

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    deq_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (dp_cmd),
        .value_in   (s_tdata),
        .m_tready   (m_tready),
        .stat       (dp_stat),
        .out_valid  (m_tvalid),
        .out_value  (m_tdata),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tuser = out_status;

    `DEQ_ASSERT_IMP(a_no_accept_when_blocked, aclk, aresetn, s_tvalid && s_tready, !m_tvalid || m_tready, "input transfer while result stalled")
    `DEQ_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, dp_stat.count <= CAP_CNT, "entry count above capacity")
    `DEQ_ASSERT_IMP(a_listing_blocks_input, aclk, aresetn, m_tvalid && !m_tlast, (m_tuser == ST_LISTED) && !s_tready, "non-final result outside a listing")
    `DEQ_ASSERT_NXT(a_push_result, aclk, aresetn, s_tvalid && s_tready && (s_tuser == OP_PUSH_FRONT || s_tuser == OP_PUSH_BACK), m_tvalid && m_tlast, "push without result")

endmodule

// File: test/tb.sv
// Testbench for double_ended_queue: drives directed and random push, pop, list
// and reserved-code transfers with random stalls on both streams and checks every
// result against a deque model. Depends on deq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module tb;
    import deq_pkg::*;

    localparam int                IDLE_LIMIT     = 2000;
    localparam int                HOLD_CYCLES    = 300;
    localparam int                HOLD_EVERY     = 150;
    localparam int                DRAIN_CYCLES   = 40;
    localparam int                RANDOM_ITEMS   = 410;
    localparam logic [OP_W-1:0]   OP_RSVD_FIRST  = 3'd5;
    localparam logic [OP_W-1:0]   OP_RSVD_MID    = 3'd6;
    localparam logic [OP_W-1:0]   OP_RSVD_LAST   = 3'd7;

    typedef struct {
        logic [OP_W-1:0] op;
        word_t           value;
        int unsigned     gap;
    } deq_cmd_item_t;

    typedef struct {
        status_t status;
        word_t   value;
        logic    last;
    } deq_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value_in (signed)
    logic [2:0]  s_tuser  = '0;   // [2:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] value_out (signed)
    logic [2:0]  m_tuser;         // [2:0] status
    logic        m_tlast;

    deq_cmd_item_t cmd_queue[$];
    deq_result_t   pending_results[$];

    // deque model state
    word_t deq_words[CAPACITY];
    int    head_slot  = 0;
    int    fill_level = 0;

    int          error_count   = 0;
    int          inputs_taken  = 0;
    int          results_taken = 0;
    int unsigned tx_gap_left   = 0;
    int unsigned rx_wait_left  = 0;
    int          hold_left     = 0;
    int          holds_done    = 0;
    int          idle_cycles   = 0;

    double_ended_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void queue_result(status_t st, word_t value, logic last);
        deq_result_t r;
        r.status = st;
        r.value  = value;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    function automatic void apply_deque_op(logic [OP_W-1:0] op, word_t value);
        int k;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (fill_level >= CAPACITY) begin
                    queue_result(ST_FULL, '0, 1'b1);
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
                        deq_words[head_slot] = value;
                    end else begin
                        deq_words[(head_slot + fill_level) % CAPACITY] = value;
                    end
                    fill_level++;
                    queue_result(ST_PUSHED, '0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (fill_level == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    if (op == OP_POP_FRONT) begin
                        queue_result(ST_POPPED, deq_words[head_slot], 1'b1);
                        head_slot = (head_slot + 1) % CAPACITY;
                    end else begin
                        queue_result(ST_POPPED,
                                     deq_words[(head_slot + fill_level - 1) % CAPACITY], 1'b1);
                    end
                    fill_level--;
                end
            end
            OP_LIST: begin
                if (fill_level == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (k = 0; k < fill_level; k++) begin
                        queue_result(ST_LISTED, deq_words[(head_slot + k) % CAPACITY],
                                     k == fill_level - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void add_cmd(logic [OP_W-1:0] op, word_t value, bit calm);
        deq_cmd_item_t it;
        it.op    = op;
        it.value = value;
        it.gap   = calm ? 0 : $urandom_range(0, 19);
        cmd_queue.push_back(it);
    endfunction

    function automatic word_t draw_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mode 0 leans to pushes, mode 1 to pops, mode 2 is balanced
    function automatic logic [OP_W-1:0] draw_op(int mode);
        int r;
        int push_pct;
        r = $urandom_range(0, 99);
        push_pct = (mode == 0) ? 88 : (mode == 1) ? 15 : 50;
        if (r < 3) begin
            return OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        end else if (r < 13) begin
            return OP_LIST;
        end else if ($urandom_range(0, 99) < push_pct) begin
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else begin
            return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        end
    endfunction

    // sender: each item is followed by its own idle gap
    always @(posedge aclk) begin
        deq_cmd_item_t it;
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            tx_gap_left <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid && tx_gap_left != 0) begin
                s_tvalid    <= 1'b0;
                tx_gap_left <= tx_gap_left - 1;
            end else if (!s_tvalid && tx_gap_left != 0) begin
                tx_gap_left <= tx_gap_left - 1;
            end else if (cmd_queue.size() != 0) begin
                it = cmd_queue.pop_front();
                s_tvalid    <= 1'b1;
                s_tuser     <= it.op;
                s_tdata     <= it.value;
                tx_gap_left <= it.gap;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-offs so the block fills and stalls its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && inputs_taken >= (holds_done + 1) * HOLD_EVERY) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // receiver: stall drawn per result; every third run of 40 results has none
    always @(posedge aclk) begin
        int unsigned w;
        if (!aresetn) begin
            m_tready     <= 1'b0;
            rx_wait_left <= 0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            w = ((results_taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 19);
            m_tready     <= (w == 0);
            rx_wait_left <= (w == 0) ? 0 : w - 1;
        end else if (rx_wait_left != 0) begin
            m_tready     <= 1'b0;
            rx_wait_left <= rx_wait_left - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // results are checked before the same edge's input is applied to the model
    always @(posedge aclk) begin
        deq_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_taken <= results_taken + 1;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual status %0d value %0d last %0b",
                             $time, m_tuser, $signed(m_tdata), m_tlast);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata !== want.value) begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.value), $signed(m_tdata));
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_deque_op(s_tuser, s_tdata);
                inputs_taken <= inputs_taken + 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int counted;
        int mode;
        int run_len;
        bit calm;
        logic [OP_W-1:0] op;

        // directed: empty store, extremes, only-entry pops, reserved codes
        add_cmd(OP_LIST,       '0,           1'b0);
        add_cmd(OP_POP_FRONT,  32'hFFFF_FFFF, 1'b0);
        add_cmd(OP_POP_BACK,   '0,           1'b1);
        add_cmd(OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1);
        add_cmd(OP_PUSH_BACK,  32'h8000_0000, 1'b0);
        add_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1);
        add_cmd(OP_PUSH_BACK,  32'h0000_0000, 1'b0);
        add_cmd(OP_LIST,       32'h1234_5678, 1'b1);
        add_cmd(OP_POP_BACK,   '0,           1'b0);
        add_cmd(OP_POP_FRONT,  '0,           1'b1);
        add_cmd(OP_POP_BACK,   '0,           1'b1);
        add_cmd(OP_POP_FRONT,  '0,           1'b0);
        add_cmd(OP_LIST,       '0,           1'b0);
        add_cmd(OP_PUSH_BACK,  32'h5A5A_5A5A, 1'b1);
        add_cmd(OP_POP_FRONT,  '0,           1'b1);
        add_cmd(OP_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0);
        add_cmd(OP_POP_FRONT,  '0,           1'b0);
        add_cmd(OP_POP_FRONT,  '0,           1'b1);
        add_cmd(OP_RSVD_FIRST, 32'hFFFF_FFFF, 1'b0);
        add_cmd(OP_RSVD_MID,   32'h0000_0001, 1'b1);
        add_cmd(OP_RSVD_LAST,  32'h8000_0000, 1'b0);
        add_cmd(OP_PUSH_BACK,  32'h0000_0001, 1'b1);
        add_cmd(OP_LIST,       '0,           1'b1);
        add_cmd(OP_POP_BACK,   '0,           1'b0);

        // random runs: fill bursts, drain bursts and mixed traffic
        counted = 0;
        mode    = 0;
        while (counted < RANDOM_ITEMS) begin
            run_len = $urandom_range(8, 40);
            calm    = ($urandom_range(0, 3) == 0);
            repeat (run_len) begin
                op = draw_op(mode);
                add_cmd(op, draw_word(), calm);
                if (op <= OP_LIST) begin
                    counted++;
                end
            end
            mode = (mode == 0) ? $urandom_range(1, 2) : $urandom_range(0, 2);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: double_ended_queue.f
+incdir+design
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/deq_datapath.sv
design/double_ended_queue.sv
test/tb.sv
